// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and fixed field widths of the LRU page frame replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned FRAME_W    = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_VREAD,
    S_EVICT,
    S_WALK,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;     // capture page, open frame scan
    logic scan;      // advance frame scan
    logic take_hit;  // matching frame found, open stack walk
    logic fill;      // load next free frame, open stack walk
    logic vsel;      // point at the bottom of the stack
    logic evict;     // refill the victim frame, open stack walk
    logic walk;      // advance stack walk
    logic emit;      // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic filled_zero;
    logic full;
    logic match;
    logic scan_end;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/lru_page_frame_replacer_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_frame_replacer_top
// LRU page frame replacer: finds the frame holding an address's page,
// refills a free or least recently used frame on a miss.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o | address_i[31:0]
//  out     | out_valid_o/ out_stall_i| hit_o, frame_o[5:0], page_number_o
//
// One item at a time. The frame table is scanned one entry per cycle, then
// the recency stack is walked one entry per cycle through single-port reads.
// Reset clears the fill count and the output valid; the memories need no
// clearing pass. A stalled result waits in the output register while the
// next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lru_page_frame_replacer_top #(
  parameter int unsigned FRAMES = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [lpfr_pkg::ADDR_W-1:0]  address_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              hit_o,
  output logic [lpfr_pkg::FRAME_W-1:0]      frame_o,
  output logic [lpfr_pkg::PAGE_W-1:0]       page_number_o
);
  import lpfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lpfr_dpath #(
    .FRAMES (FRAMES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .frame_o       (frame_o),
    .page_number_o (page_number_o)
  );

  `ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item accepted while busy")
  `ASSERT_IMP(a_fill_not_full, clk_i, rst_ni, cmd.fill, !sts.full, "fill with all frames in use")
  `ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd.emit, sts.out_free, "result overwrites pending transfer")
  `ASSERT_IMP(a_hit_match, clk_i, rst_ni, cmd.take_hit, sts.match && sts.filled_zero == 1'b0, "hit without match")

endmodule

`default_nettype wire

// ===== design/lpfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpfr_ctrl
// Sequencer: frame scan, victim fetch, recency stack walk, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output lpfr_pkg::cmd_t     cmd_o,
  input  wire lpfr_pkg::sts_t sts_i
);
  import lpfr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.filled_zero ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          state_d = S_WALK;
        end else if (sts_i.scan_end) begin
          state_d = S_MISS;
        end
      end
      S_MISS:  state_d = sts_i.full ? S_VREAD : S_WALK;
      S_VREAD: state_d = S_EVICT;
      S_EVICT: state_d = S_WALK;
      S_WALK: begin
        if (sts_i.walk_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan     = 1'b1;
        cmd_o.take_hit = sts_i.match;
      end
      S_MISS: begin
        cmd_o.fill = !sts_i.full;
        cmd_o.vsel = sts_i.full;
      end
      S_VREAD: ;
      S_EVICT: cmd_o.evict = 1'b1;
      S_WALK:  cmd_o.walk  = 1'b1;
      S_DONE:  cmd_o.emit  = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lpfr_dpath.sv =====
// ----------------------------------------------------------------------------
// lpfr_dpath
// Frame table, recency stack, fill count, scan pointers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_dpath #(
  parameter int unsigned FRAMES = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lpfr_pkg::cmd_t               cmd_i,
  output lpfr_pkg::sts_t                    sts_o,
  input  wire logic [lpfr_pkg::ADDR_W-1:0]  address_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              hit_o,
  output logic [lpfr_pkg::FRAME_W-1:0]      frame_o,
  output logic [lpfr_pkg::PAGE_W-1:0]       page_number_o
);
  import lpfr_pkg::*;

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);

  logic [PAGE_W-1:0] fpage_mem [FRAMES];
  logic [IW-1:0]     order_mem [FRAMES];

  logic [PAGE_W-1:0] page_q;
  logic [PAGE_W-1:0] fp_rd_q;
  logic [IW-1:0]     ord_rd_q;
  logic [IW-1:0]     idx_q, cmp_idx_q, frame_q, carry_q, last_q;
  logic              hit_q, pend_q;
  logic [CW-1:0]     filled_q;
  logic              out_valid_q, out_hit_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [PAGE_W-1:0] out_page_q;

  logic              open_walk;
  logic              fp_we;
  logic [IW-1:0]     fp_waddr;
  logic              ord_we;

  assign open_walk = cmd_i.start | cmd_i.take_hit | cmd_i.fill | cmd_i.evict;
  assign fp_we     = cmd_i.fill | cmd_i.evict;
  assign fp_waddr  = cmd_i.fill ? filled_q[IW-1:0] : ord_rd_q;
  assign ord_we    = cmd_i.walk & pend_q;

  always_comb begin
    sts_o.filled_zero = (filled_q == '0);
    sts_o.full        = (filled_q == CW'(FRAMES));
    sts_o.match       = pend_q && (fp_rd_q == page_q);
    sts_o.scan_end    = pend_q && (CW'(cmp_idx_q) == (filled_q - CW'(1)));
    sts_o.walk_end    = pend_q && ((cmp_idx_q == last_q) || (ord_rd_q == frame_q));
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // memories: one write, one registered read at idx_q
  always_ff @(posedge clk_i) begin
    if (fp_we) begin
      fpage_mem[fp_waddr] <= page_q;
    end
    fp_rd_q <= fpage_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[cmp_idx_q] <= carry_q;
    end
    ord_rd_q <= order_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (open_walk) begin
        pend_q <= 1'b0;
      end else if (cmd_i.scan || cmd_i.walk) begin
        pend_q <= 1'b1;
      end
      if (cmd_i.fill) begin
        filled_q <= filled_q + CW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= address_i[ADDR_W-1:PAGE_SHIFT];
    end
    if (open_walk) begin
      idx_q <= '0;
    end else if (cmd_i.vsel) begin
      idx_q <= IW'(FRAMES - 1);
    end else if (cmd_i.scan || cmd_i.walk) begin
      idx_q <= idx_q + IW'(1);
    end
    if (cmd_i.scan || cmd_i.walk) begin
      cmp_idx_q <= idx_q;
    end
    // take_hit, fill and evict are mutually exclusive
    if (cmd_i.take_hit) begin
      hit_q   <= 1'b1;
      frame_q <= cmp_idx_q;
      carry_q <= cmp_idx_q;
      last_q  <= IW'(FRAMES - 1);
    end else if (cmd_i.fill) begin
      hit_q   <= 1'b0;
      frame_q <= filled_q[IW-1:0];
      carry_q <= filled_q[IW-1:0];
      last_q  <= filled_q[IW-1:0];
    end else if (cmd_i.evict) begin
      hit_q   <= 1'b0;
      frame_q <= ord_rd_q;
      carry_q <= ord_rd_q;
      last_q  <= IW'(FRAMES - 1);
    end else if (ord_we) begin
      // shift the stack down by one, carrying the displaced entry
      carry_q <= ord_rd_q;
    end
    if (cmd_i.emit) begin
      out_hit_q   <= hit_q;
      out_frame_q <= FRAME_W'(frame_q);
      out_page_q  <= page_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign frame_o       = out_frame_q;
  assign page_number_o = out_page_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_lru_page_frame_replacer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_page_frame_replacer_top
// Self-checking bench for the LRU page frame replacer. A queue of addresses
// (directed corner cases, then a page stream drawn from a small working set
// with some fully random addresses) feeds a clocked driver. A clocked
// monitor compares every result transfer against a scoreboard filled by a
// local LRU frame table, while both sides insert random idle gaps.
// ----------------------------------------------------------------------------

module tb_lru_page_frame_replacer_top;
  import lpfr_pkg::*;

  localparam int unsigned FRAMES       = 64;
  localparam int unsigned RAND_ITEMS   = 550;
  localparam int unsigned POOL_SIZE    = 80;
  localparam int unsigned HOT_SIZE     = 8;
  localparam int unsigned DRAIN_CYCLES = 2 * FRAMES + 16;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
  } access_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [ADDR_W-1:0]  address_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic [FRAME_W-1:0] frame_o;
  logic [PAGE_W-1:0]  page_number_o;

  // local copy of the frame table and recency stack (entry 0 most recent)
  logic [PAGE_W-1:0]  resident_page [FRAMES];
  logic [FRAME_W-1:0] recency_stack [FRAMES];
  int unsigned        frames_used = 0;

  logic [ADDR_W-1:0]  pending_addr [$];
  access_t            expected_access [$];
  access_t            head_access;
  logic [PAGE_W-1:0]  page_pool [POOL_SIZE];
  int unsigned        addr_total  = 0;
  int unsigned        addr_taken  = 0;
  int unsigned        mismatches  = 0;
  int unsigned        send_gap    = 0;
  int unsigned        stall_run   = 0;
  int unsigned        free_run    = 0;

  lru_page_frame_replacer_top #(
    .FRAMES(FRAMES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .frame_o      (frame_o),
    .page_number_o(page_number_o)
  );

  // Shift the stack down over position pos and put frame f on top.
  function automatic void bump_to_front(input int unsigned pos, input logic [FRAME_W-1:0] f);
    int unsigned i;
    for (i = pos; i > 0; i--) recency_stack[i] = recency_stack[i-1];
    recency_stack[0] = f;
  endfunction

  function automatic access_t lru_access(input logic [ADDR_W-1:0] addr);
    access_t     r;
    int unsigned i;
    int unsigned pos;
    logic        found;
    r.hit   = 1'b0;
    r.frame = '0;
    r.page  = addr[ADDR_W-1:PAGE_SHIFT];
    pos     = 0;
    found   = 1'b0;
    for (i = 0; i < frames_used; i++) begin
      if (!r.hit && resident_page[i] == r.page) begin
        r.hit   = 1'b1;
        r.frame = FRAME_W'(i);
      end
    end
    if (r.hit) begin
      for (i = 0; i < frames_used; i++) begin
        if (!found && recency_stack[i] == r.frame) begin
          pos   = i;
          found = 1'b1;
        end
      end
      bump_to_front(pos, r.frame);
    end else if (frames_used < FRAMES) begin
      r.frame = FRAME_W'(frames_used);
      resident_page[r.frame] = r.page;
      bump_to_front(frames_used, r.frame);
      frames_used++;
    end else begin
      // evict the least recent frame
      r.frame = recency_stack[FRAMES-1];
      resident_page[r.frame] = r.page;
      bump_to_front(FRAMES-1, r.frame);
    end
    return r;
  endfunction

  // Mostly pages from a working set a little larger than the table, so that
  // hits at every stack depth and evictions both occur.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       r;
    logic [PAGE_W-1:0] pg;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 35) pg = page_pool[$urandom_range(0, HOT_SIZE-1)];
    else pg = page_pool[$urandom_range(0, POOL_SIZE-1)];
    return {pg, PAGE_SHIFT'($urandom)};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver: hold a stalled transfer, otherwise advance after the gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      address_i  <= '0;
      send_gap   = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        expected_access.push_back(lru_access(address_i));
        addr_taken++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_addr.size() > 0) begin
        in_valid_i <= 1'b1;
        address_i  <= pending_addr.pop_front();
        send_gap   = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and output stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run   = 0;
      free_run    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_access.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual hit %0b frame %0d page 0x%05h",
                   $time, hit_o, frame_o, page_number_o);
          mismatches++;
        end else begin
          head_access = expected_access.pop_front();
          if (hit_o !== head_access.hit) begin
            $display("%0t: hit mismatch: expected %0b, actual %0b",
                     $time, head_access.hit, hit_o);
            mismatches++;
          end
          if (frame_o !== head_access.frame) begin
            $display("%0t: frame mismatch: expected %0d, actual %0d",
                     $time, head_access.frame, frame_o);
            mismatches++;
          end
          if (page_number_o !== head_access.page) begin
            $display("%0t: page_number mismatch: expected 0x%05h, actual 0x%05h",
                     $time, head_access.page, page_number_o);
            mismatches++;
          end
        end
      end
      if (stall_run > 0) begin
        stall_run--;
        out_stall_i <= 1'b1;
      end else if (free_run > 0) begin
        free_run--;
        out_stall_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 9)) inside
          [0:4]: begin
            free_run = $urandom_range(1, 30);
            out_stall_i <= 1'b0;
          end
          [5:8]: begin
            stall_run = $urandom_range(0, 3);
            out_stall_i <= 1'b1;
          end
          default: begin
            stall_run = $urandom_range(10, 60);
            out_stall_i <= 1'b1;
          end
        endcase
      end
    end
  end

  initial begin
    int unsigned k;
    for (k = 0; k < POOL_SIZE; k++) page_pool[k] = PAGE_W'($urandom);
    // corner pages, offset-only changes that must hit, and a return to an old page
    pending_addr = {32'h0000_0000, 32'h0000_0FFF, 32'hFFFF_FFFF, 32'hFFFF_F000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_1000, 32'hAAAA_AAAA,
                    32'h5555_5555, 32'h0000_0000, 32'h8000_0FFF, 32'h0000_1001,
                    32'hFFFF_FFFF, 32'h1234_5678, 32'hFEDC_BA98, 32'h7FFF_F000};
    for (k = 0; k < RAND_ITEMS; k++) pending_addr.push_back(pick_address());
    addr_total = pending_addr.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (addr_taken == addr_total && expected_access.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/lpfr_pkg.sv
design/lpfr_ctrl.sv
design/lpfr_dpath.sv
design/lru_page_frame_replacer_top.sv
tb/sv/tb_lru_page_frame_replacer_top.sv
